// ----- rtl/closest_point_on_segment_top_macros.svh -----
// assertion macros used by the top level rtl of the nearest segment point block
`ifndef CLOSEST_POINT_ON_SEGMENT_TOP_MACROS_SVH
`define CLOSEST_POINT_ON_SEGMENT_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define CPS_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// fixed-delay implication, delay given as a constant
`define CPS_CHECK_DELAY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(dly) (cons)) \
		else $error(msg);

`endif

// ----- rtl/cpseg_pkg.sv -----
// shared types and constants of the nearest segment point block
`default_nettype none
package cpseg_pkg;
	// coordinates are signed q19.4 by default; the fraction position does not
	// change the arithmetic
	localparam int COORD_WIDTH_DEF = 24;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_X  = 3'd0,
		CFG_FIRST_Y  = 3'd1,
		CFG_FIRST_Z  = 3'd2,
		CFG_SECOND_X = 3'd3,
		CFG_SECOND_Y = 3'd4,
		CFG_SECOND_Z = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REG_INTERIOR = 2'd0,
		REG_FIRST    = 2'd1,
		REG_SECOND   = 2'd2,
		REG_DEGEN    = 2'd3
	} region_t;
endpackage
`default_nettype wire

// ----- rtl/cpseg_divider.sv -----
// pipelined rounded scaling divider: off = round(num * mag / den), one mag bit a stage
`default_nettype none
module cpseg_divider #(
	parameter int COORD_WIDTH = cpseg_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic [2*COORD_WIDTH+3:0] num,
	input  wire logic [2*COORD_WIDTH+3:0] den,
	input  wire logic [COORD_WIDTH:0]     mag,
	output logic      [COORD_WIDTH:0]     off
);
	localparam int STEPS = COORD_WIDTH + 1;
	localparam int RW    = 2 * COORD_WIDTH + 4;
	localparam int QW    = COORD_WIDTH + 1;

	logic [RW-1:0] rem_s [STEPS];
	logic [RW-1:0] num_s [STEPS];
	logic [RW-1:0] den_s [STEPS];
	logic [QW-1:0] quo_s [STEPS];
	logic [QW-1:0] mag_s [STEPS];
	logic [QW-1:0] off_q;

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		logic [RW-1:0] r_in, n_in, d_in;
		logic [QW-1:0] q_in, m_in;
		logic [RW:0]   r2, rnext;
		logic [1:0]    digit;

		if (j == 0) begin : g_first
			assign r_in = '0;
			assign q_in = '0;
			assign n_in = num;
			assign d_in = den;
			assign m_in = mag;
		end else begin : g_next
			assign r_in = rem_s[j-1];
			assign q_in = quo_s[j-1];
			assign n_in = num_s[j-1];
			assign d_in = den_s[j-1];
			assign m_in = mag_s[j-1];
		end

		// shift in the next multiplier bit, then take out up to two divisors
		assign r2 = {r_in, 1'b0} + (m_in[QW-1-j] ? {1'b0, n_in} : '0);

		always_comb begin
			priority if (r2 >= {d_in, 1'b0}) begin
				digit = 2'd2;
				rnext = r2 - {d_in, 1'b0};
			end else if (r2 >= {1'b0, d_in}) begin
				digit = 2'd1;
				rnext = r2 - {1'b0, d_in};
			end else begin
				digit = 2'd0;
				rnext = r2;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j] <= rnext[RW-1:0];
			quo_s[j] <= {q_in[QW-2:0], 1'b0} + QW'(digit);
			num_s[j] <= n_in;
			den_s[j] <= d_in;
			mag_s[j] <= m_in;
		end
	end

	// round half up on the remainder
	always_ff @(posedge clk) begin
		off_q <= quo_s[STEPS-1]
			+ QW'({rem_s[STEPS-1], 1'b0} >= {1'b0, den_s[STEPS-1]});
	end

	assign off = off_q;
endmodule
`default_nettype wire

// ----- rtl/closest_point_on_segment_top.sv -----
// top level of the nearest point on a 3d segment block
`default_nettype none
`include "closest_point_on_segment_top_macros.svh"
// Returns, for each query point, the nearest point of the segment held in the
// six endpoint registers, plus a region code. A query is taken every cycle
// (busy stays low) and its word appears on the result ports, marked by done for
// one cycle, once it has passed the pipeline; the receiver cannot stall. The
// pipeline is four stages of difference, multiply, sum and classify, then the
// divider that retires one bit of |D| per stage (COORD_WIDTH + 1 stages), its
// rounding stage and the output register. Endpoint writes are always accepted
// and must only happen while no query is in flight.
module closest_point_on_segment_top #(
	parameter int COORD_WIDTH = cpseg_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// query channel
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic signed [COORD_WIDTH-1:0]    query_x,
	input  wire logic signed [COORD_WIDTH-1:0]    query_y,
	input  wire logic signed [COORD_WIDTH-1:0]    query_z,
	// result channel
	output logic                                  done,
	output logic signed [COORD_WIDTH-1:0]         nearest_x,
	output logic signed [COORD_WIDTH-1:0]         nearest_y,
	output logic signed [COORD_WIDTH-1:0]         nearest_z,
	output logic [1:0]                            clamp_region,
	// endpoint register writes
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [cpseg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [COORD_WIDTH-1:0]           cfg_data
);
	localparam int W     = COORD_WIDTH;
	localparam int STEPS = W + 1;
	localparam int PW    = 2 * W + 2;   // one product
	localparam int SW    = 2 * W + 4;   // sum of three products
	localparam int LAT   = STEPS + 6;   // start edge to done sampled high

	// word that rides alongside the divider
	typedef struct packed {
		cpseg_pkg::region_t  region;
		logic [2:0][W-1:0]   bypass;
		logic [2:0][W-1:0]   p1;
		logic [2:0]          dneg;
	} side_t;

	// endpoint registers
	logic [2:0][W-1:0] p1_q, p2_q;

	logic accept;
	logic [2:0][W-1:0] qv;

	// stage 1: differences
	logic              v_s1;
	logic [2:0][W:0]   qp_s1, d_s1;
	logic [2:0][W-1:0] p1_s1, p2_s1;
	// stage 2: products
	logic              v_s2;
	logic [2:0][PW-1:0] pt_s2, pd_s2;
	logic [2:0][W:0]   d_s2;
	logic [2:0][W-1:0] p1_s2, p2_s2;
	// stage 3: dot products
	logic              v_s3;
	logic [SW-1:0]     t_s3, dd_s3;
	logic [2:0][W:0]   d_s3;
	logic [2:0][W-1:0] p1_s3, p2_s3;
	// stage 4: classify
	logic              v_s4;
	logic [SW-1:0]     t_s4, dd_s4;
	logic [2:0][W:0]   mag_s4;
	side_t             side_s4, side_n;

	// divider alignment
	logic              vld_s [STEPS+1];
	side_t             side_s [STEPS+1];
	logic [2:0][W:0]   off;

	// output register
	logic              done_q;
	logic [2:0][W-1:0] near_q;
	logic [1:0]        region_q;

	// result equals one of the endpoints
	logic              at_p1, at_p2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign qv        = {query_z, query_y, query_x};

	// endpoint writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q <= '0;
			p2_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cpseg_pkg::CFG_FIRST_X:  p1_q[0] <= cfg_data;
				cpseg_pkg::CFG_FIRST_Y:  p1_q[1] <= cfg_data;
				cpseg_pkg::CFG_FIRST_Z:  p1_q[2] <= cfg_data;
				cpseg_pkg::CFG_SECOND_X: p2_q[0] <= cfg_data;
				cpseg_pkg::CFG_SECOND_Y: p2_q[1] <= cfg_data;
				cpseg_pkg::CFG_SECOND_Z: p2_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// q - p1 and d = p2 - p1, one bit wider
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			qp_s1[k] <= {qv[k][W-1], qv[k]} - {p1_q[k][W-1], p1_q[k]};
			d_s1[k]  <= {p2_q[k][W-1], p2_q[k]} - {p1_q[k][W-1], p1_q[k]};
		end
		p1_s1 <= p1_q;
		p2_s1 <= p2_q;
	end

	// six signed multiplies
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			pt_s2[k] <= PW'($signed(qp_s1[k]) * $signed(d_s1[k]));
			pd_s2[k] <= PW'($signed(d_s1[k]) * $signed(d_s1[k]));
		end
		d_s2  <= d_s1;
		p1_s2 <= p1_s1;
		p2_s2 <= p2_s1;
	end

	// t = dot(q - p1, d), dd = dot(d, d)
	always_ff @(posedge clk) begin
		t_s3 <= {{2{pt_s2[0][PW-1]}}, pt_s2[0]} + {{2{pt_s2[1][PW-1]}}, pt_s2[1]}
			+ {{2{pt_s2[2][PW-1]}}, pt_s2[2]};
		dd_s3 <= {2'b00, pd_s2[0]} + {2'b00, pd_s2[1]} + {2'b00, pd_s2[2]};
		d_s3  <= d_s2;
		p1_s3 <= p1_s2;
		p2_s3 <= p2_s2;
	end

	// classify; zero length wins over the clamps
	always_comb begin
		logic [W:0] mid_sum;
		side_n.p1 = p1_s3;
		for (int k = 0; k < 3; k++) begin
			side_n.dneg[k] = d_s3[k][W];
		end
		priority if (dd_s3 == '0) begin
			side_n.region = cpseg_pkg::REG_DEGEN;
		end else if ($signed(t_s3) <= 0) begin
			side_n.region = cpseg_pkg::REG_FIRST;
		end else if ($signed(t_s3) >= $signed(dd_s3)) begin
			side_n.region = cpseg_pkg::REG_SECOND;
		end else begin
			side_n.region = cpseg_pkg::REG_INTERIOR;
		end
		for (int k = 0; k < 3; k++) begin
			// midpoint: floor of the half sum
			mid_sum = {p1_s3[k][W-1], p1_s3[k]} + {p2_s3[k][W-1], p2_s3[k]};
			unique case (side_n.region)
				cpseg_pkg::REG_DEGEN:  side_n.bypass[k] = mid_sum[W:1];
				cpseg_pkg::REG_SECOND: side_n.bypass[k] = p2_s3[k];
				default:               side_n.bypass[k] = p1_s3[k];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_n;
		t_s4    <= t_s3;
		dd_s4   <= dd_s3;
		for (int k = 0; k < 3; k++) begin
			mag_s4[k] <= d_s3[k][W] ? (~d_s3[k] + 1'b1) : d_s3[k];
		end
	end

	// one divider lane per axis
	for (genvar k = 0; k < 3; k++) begin : g_lane
		cpseg_divider #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_div (
			.clk (clk),
			.num (t_s4),
			.den (dd_s4),
			.mag (mag_s4[k]),
			.off (off[k])
		);
	end

	// side word delay line, matched to the divider latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STEPS; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[0] <= v_s4;
			for (int i = 1; i <= STEPS; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_s4;
		for (int i = 1; i <= STEPS; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	// output register: done follows the delay line; interior points get the signed offset, others the bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		region_q <= side_s[STEPS].region;
		for (int k = 0; k < 3; k++) begin
			if (side_s[STEPS].region == cpseg_pkg::REG_INTERIOR) begin
				near_q[k] <= side_s[STEPS].dneg[k]
					? side_s[STEPS].p1[k] - off[k][W-1:0]
					: side_s[STEPS].p1[k] + off[k][W-1:0];
			end else begin
				near_q[k] <= side_s[STEPS].bypass[k];
			end
		end
	end

	assign done         = done_q;
	assign nearest_x    = near_q[0];
	assign nearest_y    = near_q[1];
	assign nearest_z    = near_q[2];
	assign clamp_region = region_q;

	assign at_p1 = nearest_x == p1_q[0] && nearest_y == p1_q[1] && nearest_z == p1_q[2];
	assign at_p2 = nearest_x == p2_q[0] && nearest_y == p2_q[1] && nearest_z == p2_q[2];

	// every accepted query comes out after the fixed latency
	`CPS_CHECK_DELAY(a_latency, start && !busy, LAT, done, "query result missing")
	// a first-end clamp returns the first endpoint
	`CPS_CHECK(a_first, done && clamp_region == cpseg_pkg::REG_FIRST, at_p1, "first clamp mismatch")
	// a second-end clamp returns the second endpoint
	`CPS_CHECK(a_second, done && clamp_region == cpseg_pkg::REG_SECOND, at_p2, "second clamp mismatch")
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench of the nearest point on a 3d segment block
`default_nettype none
module testbench;
	localparam int CW = cpseg_pkg::COORD_WIDTH_DEF;
	localparam int IW = cpseg_pkg::CFG_IDX_W;
	// wait longer than the pipeline depth of the top level
	localparam int DRAIN_CYCLES = CW + 20;
	// indexes past the six endpoint registers, writes there are dropped
	localparam logic [IW-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [IW-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef logic signed [CW-1:0] coord_t;
	// packed point, element 0 is x, 1 is y, 2 is z
	typedef logic [2:0][CW-1:0] point_t;
	typedef struct packed {
		point_t             p;
		cpseg_pkg::region_t r;
	} nearest_t;
	typedef struct packed {
		point_t             p1;
		point_t             p2;
		point_t             q;
		bit                 typed;
		point_t             ex;
		cpseg_pkg::region_t ex_r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	coord_t query_x = '0, query_y = '0, query_z = '0;
	logic done;
	coord_t nearest_x, nearest_y, nearest_z;
	logic [1:0] clamp_region;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IW-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;

	closest_point_on_segment_top #(.COORD_WIDTH(CW)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.query_x(query_x), .query_y(query_y), .query_z(query_z),
		.done(done),
		.nearest_x(nearest_x), .nearest_y(nearest_y), .nearest_z(nearest_z),
		.clamp_region(clamp_region),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// 4 time unit period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// endpoint copy kept by the bench, seg_a is P1 and seg_b is P2
	coord_t seg_a[3];
	coord_t seg_b[3];
	nearest_t pending_words[$];
	row_t directed[$];
	int errors = 0;
	int queries_sent = 0;
	int words_checked = 0;
	int segments_set = 0;
	int idle_pct = 0;

	const cpseg_pkg::cfg_idx_t first_idx[3] = '{cpseg_pkg::CFG_FIRST_X,
		cpseg_pkg::CFG_FIRST_Y, cpseg_pkg::CFG_FIRST_Z};
	const cpseg_pkg::cfg_idx_t second_idx[3] = '{cpseg_pkg::CFG_SECOND_X,
		cpseg_pkg::CFG_SECOND_Y, cpseg_pkg::CFG_SECOND_Z};

	function automatic point_t pt(coord_t x, coord_t y, coord_t z);
		point_t p;
		p[0] = x;
		p[1] = y;
		p[2] = z;
		return p;
	endfunction

	// exact nearest point: t and dd held in 128 bits, no square root
	function automatic nearest_t nearest_of(point_t q);
		logic signed [127:0] t, dd, ak, bk, qk, s, mag, off;
		logic signed [127:0] dk[3];
		nearest_t n;
		coord_t qc;
		t = 0;
		dd = 0;
		for (int k = 0; k < 3; k++) begin
			qc = q[k];
			qk = qc;
			ak = seg_a[k];
			bk = seg_b[k];
			dk[k] = bk - ak;
			t = t + (qk - ak) * dk[k];
			dd = dd + dk[k] * dk[k];
		end
		for (int k = 0; k < 3; k++) begin
			ak = seg_a[k];
			bk = seg_b[k];
			if (dd == 0) begin
				// zero-length segment: floor of the endpoint average
				s = ak + bk;
				n.p[k] = CW'(s >>> 1);
			end else if (t <= 0) begin
				n.p[k] = seg_a[k];
			end else if (t >= dd) begin
				n.p[k] = seg_b[k];
			end else begin
				// offset rounded on its magnitude, ties away from zero
				mag = (dk[k] < 0) ? -dk[k] : dk[k];
				off = (2 * t * mag + dd) / (2 * dd);
				n.p[k] = CW'((dk[k] < 0) ? ak - off : ak + off);
			end
		end
		if (dd == 0) n.r = cpseg_pkg::REG_DEGEN;
		else if (t <= 0) n.r = cpseg_pkg::REG_FIRST;
		else if (t >= dd) n.r = cpseg_pkg::REG_SECOND;
		else n.r = cpseg_pkg::REG_INTERIOR;
		return n;
	endfunction

	task automatic report(string what, nearest_t got, nearest_t want);
		errors++;
		$display("mismatch %s: got %0d %0d %0d r%0d, want %0d %0d %0d r%0d", what,
			coord_t'(got.p[0]), coord_t'(got.p[1]), coord_t'(got.p[2]), got.r,
			coord_t'(want.p[0]), coord_t'(want.p[1]), coord_t'(want.p[2]), want.r);
	endtask

	// result checker, a word is on the ports for exactly one cycle
	always @(posedge clk) begin
		nearest_t got, want;
		if (arst_n && done) begin
			got.p = pt(nearest_x, nearest_y, nearest_z);
			got.r = cpseg_pkg::region_t'(clamp_region);
			if (pending_words.size() == 0) begin
				report("unexpected word", got, got);
			end else begin
				want = pending_words.pop_front();
				words_checked++;
				if (got.p[0] !== want.p[0]) report("nearest_x", got, want);
				else if (got.p[1] !== want.p[1]) report("nearest_y", got, want);
				else if (got.p[2] !== want.p[2]) report("nearest_z", got, want);
				else if (got.r !== want.r) report("clamp_region", got, want);
			end
		end
	end

	// one register write; called at a falling edge, leaves cfg_valid high
	task automatic write_reg(logic [IW-1:0] idx, coord_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx < 3) seg_a[idx] = val;
		else if (idx < 6) seg_b[idx - 3] = val;
		@(negedge clk);
	endtask

	// let every word in flight come out before touching the endpoints
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_segment(point_t p1, point_t p2);
		wait_idle();
		for (int k = 0; k < 3; k++) write_reg(first_idx[k], p1[k]);
		for (int k = 0; k < 3; k++) write_reg(second_idx[k], p2[k]);
		cfg_valid <= 1'b0;
		segments_set++;
	endtask

	// one query word; called at a falling edge, start may already be high
	task automatic send_query(point_t q, bit typed, nearest_t typed_word);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start <= 1'b1;
		query_x <= q[0];
		query_y <= q[1];
		query_z <= q[2];
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_words.push_back(typed ? typed_word : nearest_of(q));
		queries_sent++;
		@(negedge clk);
	endtask

	function automatic coord_t any_coord();
		return coord_t'($urandom());
	endfunction

	function automatic coord_t near_coord(int span);
		return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
	endfunction

	// point along the segment, a little past either end, plus jitter
	function automatic point_t along_segment(int jitter);
		logic signed [127:0] frac, a, b, v;
		point_t q;
		frac = $urandom_range(0, 384);
		frac = frac - 64;
		for (int k = 0; k < 3; k++) begin
			a = seg_a[k];
			b = seg_b[k];
			v = a + ((b - a) * frac) / 256 + near_coord(jitter);
			q[k] = CW'(v);
		end
		return q;
	endfunction

	task automatic random_segment();
		point_t p1, p2;
		int kind;
		kind = $urandom_range(0, 4);
		for (int k = 0; k < 3; k++) begin
			case (kind)
				0: begin
					p1[k] = any_coord();
					p2[k] = any_coord();
				end
				1, 2: begin
					p1[k] = near_coord(3000);
					p2[k] = near_coord(3000);
				end
				3: begin
					// zero-length segment
					p1[k] = any_coord();
					p2[k] = p1[k];
				end
				default: begin
					p1[k] = $urandom_range(1) ? C_MAX : C_MIN;
					p2[k] = $urandom_range(1) ? C_MAX : near_coord(8);
				end
			endcase
		end
		set_segment(p1, p2);
	endtask

	task automatic random_phase(int pct, int segments, int per_segment);
		nearest_t none;
		point_t q;
		none = '0;
		idle_pct = pct;
		for (int s = 0; s < segments; s++) begin
			random_segment();
			for (int i = 0; i < per_segment; i++) begin
				case ($urandom_range(0, 9))
					0, 1: q = pt(any_coord(), any_coord(), any_coord());
					2: q = pt(seg_a[0], seg_a[1], seg_a[2]);
					default: q = along_segment($urandom_range(1) ? 0 : 40);
				endcase
				send_query(q, 1'b0, none);
			end
		end
	endtask

	initial begin
		row_t r;
		nearest_t w;
		seg_a = '{default: '0};
		seg_b = '{default: '0};

		// directed rows: typed expectations where they are obvious
		directed.push_back('{pt(0, 0, 0), pt(0, 0, 0), pt(C_MAX, C_MIN, 5),
			1'b1, pt(0, 0, 0), cpseg_pkg::REG_DEGEN});
		directed.push_back('{pt(C_MAX, C_MAX, C_MAX), pt(C_MAX, C_MAX, C_MAX), pt(1, 2, 3),
			1'b1, pt(C_MAX, C_MAX, C_MAX), cpseg_pkg::REG_DEGEN});
		directed.push_back('{pt(C_MIN, C_MIN, C_MIN), pt(C_MIN, C_MIN, C_MIN), pt(0, 0, 0),
			1'b1, pt(C_MIN, C_MIN, C_MIN), cpseg_pkg::REG_DEGEN});
		// short segment off the axes
		directed.push_back('{pt(-3, 3, 0), pt(0, 0, 1), pt(0, 0, 0),
			1'b0, '0, cpseg_pkg::REG_DEGEN});
		directed.push_back('{pt(0, 0, 0), pt(16, 0, 0), pt(-100, 7, 7),
			1'b1, pt(0, 0, 0), cpseg_pkg::REG_FIRST});
		directed.push_back('{pt(0, 0, 0), pt(16, 0, 0), pt(1000, 7, 7),
			1'b1, pt(16, 0, 0), cpseg_pkg::REG_SECOND});
		directed.push_back('{pt(0, 0, 0), pt(16, 0, 0), pt(8, 5, 5),
			1'b1, pt(8, 0, 0), cpseg_pkg::REG_INTERIOR});
		// t exactly zero and t exactly dd
		directed.push_back('{pt(0, 0, 0), pt(16, 0, 0), pt(0, 9, 9),
			1'b1, pt(0, 0, 0), cpseg_pkg::REG_FIRST});
		directed.push_back('{pt(0, 0, 0), pt(16, 0, 0), pt(16, 3, 3),
			1'b1, pt(16, 0, 0), cpseg_pkg::REG_SECOND});
		// half-way offsets round away from zero on both signs of D
		directed.push_back('{pt(0, 0, 0), pt(2, 2, 0), pt(1, 0, 0),
			1'b1, pt(1, 1, 0), cpseg_pkg::REG_INTERIOR});
		directed.push_back('{pt(0, 0, 0), pt(-2, -2, 0), pt(-1, 0, 0),
			1'b1, pt(-1, -1, 0), cpseg_pkg::REG_INTERIOR});
		directed.push_back('{pt(5, -7, 9), pt(-11, 13, 2), pt(1, 1, 1),
			1'b0, '0, cpseg_pkg::REG_INTERIOR});
		// widest segment, corner to corner
		directed.push_back('{pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MAX, C_MAX),
			pt(C_MAX, C_MAX, C_MAX), 1'b1, pt(C_MAX, C_MAX, C_MAX),
			cpseg_pkg::REG_SECOND});
		directed.push_back('{pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MAX, C_MAX),
			pt(C_MIN, C_MIN, C_MIN), 1'b1, pt(C_MIN, C_MIN, C_MIN),
			cpseg_pkg::REG_FIRST});
		directed.push_back('{pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MAX, C_MAX),
			pt(0, 0, 0), 1'b0, '0, cpseg_pkg::REG_INTERIOR});
		directed.push_back('{pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MAX, C_MAX),
			pt(C_MAX, C_MIN, 1), 1'b0, '0, cpseg_pkg::REG_INTERIOR});
		directed.push_back('{pt(C_MAX, 0, C_MIN), pt(C_MIN, 1, C_MAX),
			pt(-5, C_MAX, 77), 1'b0, '0, cpseg_pkg::REG_INTERIOR});

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			r = directed[i];
			if (r.p1 != {seg_a[2], seg_a[1], seg_a[0]} ||
					r.p2 != {seg_b[2], seg_b[1], seg_b[0]} || i == 0)
				set_segment(r.p1, r.p2);
			w.p = r.ex;
			w.r = r.ex_r;
			send_query(r.q, r.typed, w);
		end

		// writes past the last register must leave the endpoints alone
		wait_idle();
		write_reg(CFG_SPARE_LO, any_coord());
		write_reg(CFG_SPARE_HI, any_coord());
		cfg_valid <= 1'b0;
		w = '0;
		send_query(pt(3, 4, 5), 1'b0, w);
		send_query(pt(C_MAX, C_MAX, C_MAX), 1'b0, w);

		// random part in three idling phases
		random_phase(22, 5, 130);
		random_phase(53, 5, 130);
		random_phase(0, 5, 130);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d queries on %0d segments, %0d words checked",
			queries_sent, segments_set, words_checked);
		if (errors == 0 && pending_words.size() == 0) begin
			$display("[closest_point_on_segment_top] OK");
		end else begin
			$display("[closest_point_on_segment_top] ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("timeout with %0d words outstanding", pending_words.size());
		$display("[closest_point_on_segment_top] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
